### design/sps_pkg.sv
`timescale 1ns / 1ps

package sps_pkg;

  // Command codes carried in the command field.
  localparam int unsigned CMD_W = 4;
  localparam logic [CMD_W-1:0] CMD_TICK        = 4'd0;
  localparam logic [CMD_W-1:0] CMD_TOGGLE_RUN  = 4'd1;
  localparam logic [CMD_W-1:0] CMD_FORWARD     = 4'd2;
  localparam logic [CMD_W-1:0] CMD_REVERSE     = 4'd3;
  localparam logic [CMD_W-1:0] CMD_FASTER      = 4'd4;
  localparam logic [CMD_W-1:0] CMD_SLOWER      = 4'd5;
  localparam logic [CMD_W-1:0] CMD_MANUAL      = 4'd6;
  localparam logic [CMD_W-1:0] CMD_RELEASE     = 4'd7;
  localparam logic [CMD_W-1:0] CMD_LOAD_PERIOD = 4'd8;

  // Field widths.
  localparam int unsigned PHASES     = 4;
  localparam int unsigned PHASE_W    = $clog2(PHASES);
  localparam int unsigned DRIVE_W    = 8;
  localparam int unsigned COUNT_W    = 32;
  localparam int unsigned PERIOD_W   = 32;
  localparam int unsigned FRAC_W     = 8;
  localparam int unsigned PERIOD_Q_W = PERIOD_W + FRAC_W;
  localparam int unsigned PATTERN_W  = PHASES * DRIVE_W;

  // Configuration port.
  localparam int unsigned CFG_ADDR_W = 3;
  localparam int unsigned CFG_DATA_W = 32;
  localparam logic REG_PHASE_PATTERN = 1'b0;

  // Reset values and speed scaling constants (Q16 multipliers).
  localparam logic [PATTERN_W-1:0]  PATTERN_RESET   = 32'h2812_2411;
  localparam logic [PERIOD_Q_W-1:0] PERIOD_RESET_Q8 = 40'd25_600_000;
  localparam logic [15:0]           FASTER_MUL      = 16'd62415;
  localparam logic [16:0]           SLOWER_MUL      = 17'd68813;
  localparam int unsigned           MUL_SHIFT       = 16;

endpackage

### design/sps_cmd_if.sv
`timescale 1ns / 1ps

interface sps_cmd_if;
  logic                            valid;
  logic                            ready;
  logic [sps_pkg::CMD_W-1:0]       command;
  logic [sps_pkg::PHASE_W-1:0]     phase_select;
  logic [sps_pkg::PERIOD_W-1:0]    period_value;

  modport source (output valid, command, phase_select, period_value, input ready);
  modport sink   (input valid, command, phase_select, period_value, output ready);
endinterface

### design/sps_res_if.sv
`timescale 1ns / 1ps

interface sps_res_if;
  logic                          valid;
  logic                          ready;
  logic [sps_pkg::DRIVE_W-1:0]   drive_byte;
  logic                          drive_strobe;
  logic                          is_running;
  logic [sps_pkg::COUNT_W-1:0]   steps_this_run;
  logic [sps_pkg::COUNT_W-1:0]   steps_last_run;

  modport source (output valid, drive_byte, drive_strobe, is_running, steps_this_run,
                  steps_last_run, input ready);
  modport sink   (input valid, drive_byte, drive_strobe, is_running, steps_this_run,
                  steps_last_run, output ready);
endinterface

### design/stepper_phase_sequencer.sv
`timescale 1ns / 1ps

// Full-step sequencer for a bipolar stepper motor.
// Commands arrive as beats on the cmd channel (tick, toggle run, direction,
// faster, slower, manual phase, release, load period). Every command beat
// produces exactly one beat on the result channel carrying the drive byte,
// its strobe, the run flag and both step counters as they stand after the
// command. Tick beats normally come from a free-running timebase.
// An accepted command beat is held in the input register, then the state
// update writes its result beat into the result register. One command is
// taken every cycle while the receiver keeps up; the rate is set by the single
// combinational update of the state (tick compare, step, period scaling).
// When the receiver stalls, the result register holds its beat and the input
// register takes one more command before cmd.ready drops.
// The APB port holds the phase pattern table (four drive bytes, entry 0 in
// the low byte); write it only while no command is in flight.
// Synchronous reset empties both registers, stops the run, selects forward,
// sets phase 0, a period of 100000 ticks, a saturated tick counter, zero
// step counts and the default pattern table.
module stepper_phase_sequencer (
  input  logic                             clk,
  input  logic                             rst,
  sps_cmd_if.sink                          cmd,
  sps_res_if.source                        result,
  input  logic                             psel,
  input  logic                             penable,
  input  logic                             pwrite,
  input  logic [sps_pkg::CFG_ADDR_W-1:0]   paddr,
  input  logic [sps_pkg::CFG_DATA_W-1:0]   pwdata,
  output logic [sps_pkg::CFG_DATA_W-1:0]   prdata,
  output logic                             pready
);

  localparam int unsigned FAST_PROD_W = sps_pkg::PERIOD_Q_W + 16;
  localparam int unsigned SLOW_PROD_W = sps_pkg::PERIOD_Q_W + 17;

  // Configuration register.
  logic [sps_pkg::PATTERN_W-1:0] phase_pattern;
  logic                          cfg_write;

  // Input register.
  logic                          in_valid;
  logic [sps_pkg::CMD_W-1:0]     in_command;
  logic [sps_pkg::PHASE_W-1:0]   in_phase_select;
  logic [sps_pkg::PERIOD_W-1:0]  in_period_value;

  // Sequencer state.
  logic [sps_pkg::PHASE_W-1:0]    phase_index, phase_index_next;
  logic                           reverse_dir, reverse_dir_next;
  logic                           running, running_next;
  logic [sps_pkg::PERIOD_Q_W-1:0] period_q8, period_q8_next;
  logic [sps_pkg::PERIOD_W-1:0]   elapsed_ticks, elapsed_ticks_next;
  logic [sps_pkg::COUNT_W-1:0]    run_steps, run_steps_next;
  logic [sps_pkg::COUNT_W-1:0]    latched_steps, latched_steps_next;
  logic [sps_pkg::DRIVE_W-1:0]    drive_next;
  logic                           strobe_next;

  // Result register.
  logic                           out_valid;
  logic [sps_pkg::DRIVE_W-1:0]    out_drive;
  logic                           out_strobe;

  // Datapath helpers.
  logic                           advance;
  logic [sps_pkg::PERIOD_W-1:0]   elapsed_inc;
  logic                           period_reached;
  logic [sps_pkg::PHASE_W-1:0]    phase_stepped;
  logic [FAST_PROD_W-1:0]         fast_prod;
  logic [SLOW_PROD_W-1:0]         slow_prod;
  logic [sps_pkg::PERIOD_Q_W-1:0] fast_cand;
  logic [sps_pkg::PERIOD_Q_W:0]   slow_cand;
  logic [sps_pkg::PERIOD_W-1:0]   load_value;

  // APB register access; pready is tied high.
  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && pready
                     && (paddr[2] == sps_pkg::REG_PHASE_PATTERN);
  assign prdata    = (paddr[2] == sps_pkg::REG_PHASE_PATTERN) ? phase_pattern : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      phase_pattern <= sps_pkg::PATTERN_RESET;
    end else if (cfg_write) begin
      phase_pattern <= pwdata;
    end
  end

  // Handshake: the held command moves on when the result register is free.
  assign advance    = in_valid && (!out_valid || result.ready);
  assign cmd.ready  = !in_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (cmd.ready) begin
      in_valid <= cmd.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.valid && cmd.ready) begin
      in_command      <= cmd.command;
      in_phase_select <= cmd.phase_select;
      in_period_value <= cmd.period_value;
    end
  end

  // Tick counter saturates at all ones and clears once the period is reached.
  assign elapsed_inc    = (&elapsed_ticks) ? elapsed_ticks : elapsed_ticks + 1'b1;
  assign period_reached = elapsed_inc >= period_q8[sps_pkg::PERIOD_Q_W-1:sps_pkg::FRAC_W];
  assign phase_stepped  = reverse_dir ? phase_index - 1'b1 : phase_index + 1'b1;

  // Period scaling by constant Q16 factors.
  assign fast_prod  = FAST_PROD_W'(period_q8) * FAST_PROD_W'(sps_pkg::FASTER_MUL);
  assign slow_prod  = SLOW_PROD_W'(period_q8) * SLOW_PROD_W'(sps_pkg::SLOWER_MUL);
  assign fast_cand  = fast_prod[FAST_PROD_W-1:sps_pkg::MUL_SHIFT];
  assign slow_cand  = slow_prod[SLOW_PROD_W-1:sps_pkg::MUL_SHIFT];
  assign load_value = (in_period_value == '0) ? sps_pkg::PERIOD_W'(1) : in_period_value;

  // Next state and result for the held command.
  always_comb begin
    phase_index_next   = phase_index;
    reverse_dir_next   = reverse_dir;
    running_next       = running;
    period_q8_next     = period_q8;
    elapsed_ticks_next = elapsed_ticks;
    run_steps_next     = run_steps;
    latched_steps_next = latched_steps;
    drive_next         = '0;
    strobe_next        = 1'b0;
    unique case (in_command)
      sps_pkg::CMD_TICK: begin
        elapsed_ticks_next = elapsed_inc;
        if (period_reached) begin
          elapsed_ticks_next = '0;
          if (running) begin
            phase_index_next = phase_stepped;
            drive_next       = phase_pattern[{phase_stepped, 3'b000} +: sps_pkg::DRIVE_W];
            strobe_next      = 1'b1;
            run_steps_next   = run_steps + 1'b1;
          end
        end
      end
      sps_pkg::CMD_TOGGLE_RUN: begin
        running_next = !running;
        if (running) begin
          strobe_next        = 1'b1;
          latched_steps_next = run_steps;
          run_steps_next     = '0;
        end
      end
      sps_pkg::CMD_FORWARD: begin
        reverse_dir_next = 1'b0;
      end
      sps_pkg::CMD_REVERSE: begin
        reverse_dir_next = 1'b1;
      end
      sps_pkg::CMD_FASTER: begin
        // Keep the period at one tick or more.
        if (|fast_cand[sps_pkg::PERIOD_Q_W-1:sps_pkg::FRAC_W]) begin
          period_q8_next = fast_cand;
        end
      end
      sps_pkg::CMD_SLOWER: begin
        period_q8_next = slow_cand[sps_pkg::PERIOD_Q_W] ? '1
                                                        : slow_cand[sps_pkg::PERIOD_Q_W-1:0];
      end
      sps_pkg::CMD_MANUAL: begin
        drive_next  = phase_pattern[{in_phase_select, 3'b000} +: sps_pkg::DRIVE_W];
        strobe_next = 1'b1;
      end
      sps_pkg::CMD_RELEASE: begin
        strobe_next = 1'b1;
      end
      sps_pkg::CMD_LOAD_PERIOD: begin
        period_q8_next = {load_value, sps_pkg::FRAC_W'(0)};
      end
      default: begin
      end
    endcase
  end

  // State registers update as the command moves into the result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      phase_index   <= '0;
      reverse_dir   <= 1'b0;
      running       <= 1'b0;
      period_q8     <= sps_pkg::PERIOD_RESET_Q8;
      elapsed_ticks <= '1;
      run_steps     <= '0;
      latched_steps <= '0;
    end else if (advance) begin
      phase_index   <= phase_index_next;
      reverse_dir   <= reverse_dir_next;
      running       <= running_next;
      period_q8     <= period_q8_next;
      elapsed_ticks <= elapsed_ticks_next;
      run_steps     <= run_steps_next;
      latched_steps <= latched_steps_next;
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (result.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_drive  <= drive_next;
      out_strobe <= strobe_next;
    end
  end

  // Status fields mirror the state registers, which hold while the beat waits.
  assign result.valid          = out_valid;
  assign result.drive_byte     = out_drive;
  assign result.drive_strobe   = out_strobe;
  assign result.is_running     = running;
  assign result.steps_this_run = run_steps;
  assign result.steps_last_run = latched_steps;

  // A stop latches the count, clears it and leaves the run flag low.
  assert property (@(posedge clk) disable iff (rst)
    (advance && in_command == sps_pkg::CMD_TOGGLE_RUN && running)
    |=> (!running && run_steps == '0 && latched_steps == $past(run_steps)))
    else $error("stop did not latch and clear the step count");

  // Commands other than tick and toggle run never touch the step counters.
  assert property (@(posedge clk) disable iff (rst)
    (advance && in_command != sps_pkg::CMD_TICK && in_command != sps_pkg::CMD_TOGGLE_RUN)
    |=> ($stable(run_steps) && $stable(latched_steps)))
    else $error("step counters changed on a non-stepping command");

  // A step on a tick raises the count by one and strobes the new phase.
  assert property (@(posedge clk) disable iff (rst)
    (advance && in_command == sps_pkg::CMD_TICK && running && period_reached)
    |=> (run_steps == $past(run_steps) + 1'b1 && out_strobe && elapsed_ticks == '0))
    else $error("tick step did not count or strobe");

  // The period never drops below one whole tick.
  assert property (@(posedge clk) disable iff (rst)
    advance |=> (|period_q8[sps_pkg::PERIOD_Q_W-1:sps_pkg::FRAC_W]))
    else $error("step period fell below one tick");

  // A beat without strobe carries a zero drive byte.
  assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_strobe) |-> (out_drive == '0))
    else $error("drive byte set without strobe");

endmodule
